@@ src/bmv_pkg.sv @@
// Shared types and constants for the block-scaled int8 matrix-vector core.
// No dependencies; used by every module under src.
package bmv_pkg;

  localparam int BlockLen  = 256;  // elements per scaled block
  localparam int ScaleFrac = 12;   // fraction bits of the Q4.12 block scale
  localparam int CntW      = $clog2(BlockLen);
  localparam int FifoDepth = 4;
  localparam int PtrW      = $clog2(FifoDepth);
  localparam int FillW     = $clog2(FifoDepth + 1);

  localparam int WeightW = 8;
  localparam int ActW    = 16;
  localparam int ScaleW  = 16;
  localparam int ProdW   = WeightW + ActW;   // weight * activation
  localparam int BlkW    = 32;               // block sum
  localparam int RowW    = 48;               // row sum / row result
  localparam int RowNumW = 16;

  localparam int InDataW  = 40;  // weight + activation + block_scale
  localparam int OutDataW = 64;  // row_result + row_number

  // One classified element handed from the front to the back.
  typedef struct packed {
    logic signed [ProdW-1:0]  prod;
    logic signed [ScaleW-1:0] scale;
    logic                     close;  // fold the block sum into the row sum
    logic                     eor;    // emit the row after folding
  } bmv_entry_t;

  typedef enum logic [2:0] {
    StAcc  = 3'b001,
    StMul  = 3'b010,
    StFold = 3'b100
  } bmv_state_e;

endpackage

@@ src/bmv_fifo.sv @@
// Short flip-flop queue of classified elements between front and back.
// Depends on bmv_pkg.
module bmv_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  bmv_pkg::bmv_entry_t push_data_i,
  output logic                full_o,
  input  logic                pop_i,
  output bmv_pkg::bmv_entry_t pop_data_o,
  output logic                empty_o
);

  bmv_pkg::bmv_entry_t             mem_q [bmv_pkg::FifoDepth];
  logic [bmv_pkg::PtrW-1:0]        wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [bmv_pkg::FillW-1:0]       fill_q, fill_d;
  logic                            do_push, do_pop;

  assign full_o     = (fill_q == bmv_pkg::FillW'(bmv_pkg::FifoDepth));
  assign empty_o    = (fill_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == bmv_pkg::PtrW'(bmv_pkg::FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == bmv_pkg::PtrW'(bmv_pkg::FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ src/bmv_front.sv @@
// Input side: takes stream items, forms weight*activation and marks block ends.
// Depends on bmv_pkg.
module bmv_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [bmv_pkg::WeightW-1:0] weight_i,
  input  logic signed [bmv_pkg::ActW-1:0]    activation_i,
  input  logic signed [bmv_pkg::ScaleW-1:0]  block_scale_i,
  input  logic                           end_of_row_i,
  input  logic                           fifo_full_i,
  output logic                           push_o,
  output bmv_pkg::bmv_entry_t            entry_o
);

  logic [bmv_pkg::CntW-1:0] cnt_q, cnt_d;
  logic                     close;

  assign in_ready_o = !fifo_full_i;
  assign push_o     = in_valid_i && !fifo_full_i;

  // A block closes on its last element or early at the end of a row.
  assign close = end_of_row_i || (cnt_q == bmv_pkg::CntW'(bmv_pkg::BlockLen - 1));

  always_comb begin
    entry_o.prod  = weight_i * activation_i;
    entry_o.scale = block_scale_i;
    entry_o.close = close;
    entry_o.eor   = end_of_row_i;
    cnt_d = cnt_q;
    if (push_o) begin
      cnt_d = close ? '0 : cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

@@ src/bmv_back.sv @@
// Execution side: block accumulation, scale multiply, row fold and result register.
// Depends on bmv_pkg.
module bmv_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            fifo_empty_i,
  input  bmv_pkg::bmv_entry_t             entry_i,
  output logic                            pop_o,
  input  logic                            cfg_we_i,
  input  logic [bmv_pkg::RowNumW-1:0]     cfg_wdata_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [bmv_pkg::RowW-1:0] row_result_o,
  output logic [bmv_pkg::RowNumW-1:0]     row_number_o
);

  localparam int RowW = bmv_pkg::RowW;
  localparam int BlkW = bmv_pkg::BlkW;

  bmv_pkg::bmv_state_e              state_q, state_d;
  logic signed [BlkW-1:0]           blk_q, blk_d;
  logic signed [BlkW-1:0]           mul_a_q;
  logic signed [bmv_pkg::ScaleW-1:0] mul_b_q;
  logic                             eor_q;
  logic signed [RowW-1:0]           prod_q;
  logic signed [RowW-1:0]           row_q, row_d;
  logic [bmv_pkg::RowNumW-1:0]      rownum_q, rownum_d;
  logic                             out_valid_q, out_valid_d;
  logic signed [RowW-1:0]           out_res_q;
  logic [bmv_pkg::RowNumW-1:0]      out_num_q;

  logic signed [BlkW:0]   blk_sum;
  logic signed [BlkW-1:0] blk_sat;
  logic signed [RowW-1:0] term;
  logic signed [RowW:0]   row_sum;
  logic signed [RowW-1:0] row_sat;
  logic                   out_free;
  logic                   load_out;

  // Saturating block accumulate.
  assign blk_sum = {blk_q[BlkW-1], blk_q}
                 + (BlkW+1)'(entry_i.prod);
  always_comb begin
    if (blk_sum[BlkW] != blk_sum[BlkW-1]) begin
      blk_sat = blk_sum[BlkW] ? {1'b1, {(BlkW-1){1'b0}}} : {1'b0, {(BlkW-1){1'b1}}};
    end else begin
      blk_sat = blk_sum[BlkW-1:0];
    end
  end

  // Arithmetic shift floors; saturating add into the row sum.
  assign term    = prod_q >>> bmv_pkg::ScaleFrac;
  assign row_sum = {row_q[RowW-1], row_q} + {term[RowW-1], term};
  always_comb begin
    if (row_sum[RowW] != row_sum[RowW-1]) begin
      row_sat = row_sum[RowW] ? {1'b1, {(RowW-1){1'b0}}} : {1'b0, {(RowW-1){1'b1}}};
    end else begin
      row_sat = row_sum[RowW-1:0];
    end
  end

  assign out_free = !out_valid_q || out_ready_i;
  assign pop_o    = (state_q == bmv_pkg::StAcc) && !fifo_empty_i;
  assign load_out = (state_q == bmv_pkg::StFold) && eor_q && out_free;

  always_comb begin
    state_d     = state_q;
    blk_d       = blk_q;
    row_d       = row_q;
    rownum_d    = rownum_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      bmv_pkg::StAcc: begin
        if (pop_o) begin
          if (entry_i.close) begin
            blk_d   = '0;
            state_d = bmv_pkg::StMul;
          end else begin
            blk_d = blk_sat;
          end
        end
      end
      bmv_pkg::StMul: begin
        state_d = bmv_pkg::StFold;
      end
      bmv_pkg::StFold: begin
        if (!eor_q) begin
          row_d   = row_sat;
          state_d = bmv_pkg::StAcc;
        end else if (out_free) begin
          row_d       = '0;
          rownum_d    = rownum_q + 1'b1;
          out_valid_d = 1'b1;
          state_d     = bmv_pkg::StAcc;
        end
      end
      default: begin
        state_d = bmv_pkg::StAcc;
      end
    endcase
    if (cfg_we_i) begin
      rownum_d = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bmv_pkg::StAcc;
      blk_q       <= '0;
      row_q       <= '0;
      rownum_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      blk_q       <= blk_d;
      row_q       <= row_d;
      rownum_q    <= rownum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && entry_i.close) begin
      mul_a_q <= blk_sat;
      mul_b_q <= entry_i.scale;
      eor_q   <= entry_i.eor;
    end
    if (state_q == bmv_pkg::StMul) begin
      prod_q <= mul_a_q * RowW'(mul_b_q);
    end
    if (load_out) begin
      out_res_q <= row_sat;
      out_num_q <= rownum_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign row_result_o = out_res_q;
  assign row_number_o = out_num_q;

`ifndef SYNTHESIS
  a_mul_then_fold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bmv_pkg::StMul) |=> (state_q == bmv_pkg::StFold))
    else $error("multiply step not followed by fold");

  a_blk_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bmv_pkg::StMul) |-> (blk_q == '0))
    else $error("block sum not cleared after block close");

  a_out_from_fold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == bmv_pkg::StFold && $past(eor_q)))
    else $error("result raised outside an end-of-row fold");

  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != bmv_pkg::StAcc) |-> !pop_o)
    else $error("queue popped while folding");
`endif

endmodule

@@ src/block_scaled_int8_matvec_core.sv @@
// Top level of the block-scaled int8 matrix-vector core.
// Depends on bmv_pkg, bmv_front, bmv_fifo and bmv_back.
//
// Usage:
//   s_axis carries one matrix element per item: weight (int8), activation
//   (Q8.8) and block_scale (Q4.12), with tlast marking the last element of a
//   row. Every BlockLen elements, and at row end, the block sum is scaled,
//   floored by ScaleFrac bits and added, saturating to 48 bits, to the row.
//   m_axis carries one item per row: the saturated row result and its index.
//   cfg_we_i/cfg_wdata_i load the row index of the next result at once.
// Throughput: one item per cycle into a 4-entry queue while it is not full; the
//   back end drains one element per cycle, but an element that closes a block
//   holds it through accumulate, 32x16 scale multiply and row fold.
// Path: the tlast item goes through the queue, the accumulate, multiply and
//   fold states and the output register before its row shows on m_axis.
// Reset: sums, element count and row index clear; the queue empties.
// Stall: a held result stays in the output register; the back end keeps
//   accumulating until the next row result needs that register, and s_axis
//   is held off only once the queue fills.
module block_scaled_int8_matvec_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // tdata: weight[7:0], activation[23:8], block_scale[39:24]
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [bmv_pkg::InDataW-1:0]     s_axis_tdata,
  input  logic                            s_axis_tlast,   // end_of_row
  // tdata: row_result[47:0], row_number[63:48]
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [bmv_pkg::OutDataW-1:0]    m_axis_tdata,
  input  logic                            cfg_we_i,
  input  logic [bmv_pkg::RowNumW-1:0]     cfg_wdata_i
);

  bmv_pkg::bmv_entry_t              push_entry, pop_entry;
  logic                             push, pop, fifo_full, fifo_empty;
  logic signed [bmv_pkg::RowW-1:0]  row_result;
  logic [bmv_pkg::RowNumW-1:0]      row_number;

  bmv_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .weight_i      (s_axis_tdata[7:0]),
    .activation_i  (s_axis_tdata[23:8]),
    .block_scale_i (s_axis_tdata[39:24]),
    .end_of_row_i  (s_axis_tlast),
    .fifo_full_i   (fifo_full),
    .push_o        (push),
    .entry_o       (push_entry)
  );

  bmv_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_entry),
    .full_o      (fifo_full),
    .pop_i       (pop),
    .pop_data_o  (pop_entry),
    .empty_o     (fifo_empty)
  );

  bmv_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_empty_i (fifo_empty),
    .entry_i      (pop_entry),
    .pop_o        (pop),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .row_result_o (row_result),
    .row_number_o (row_number)
  );

  assign m_axis_tdata = {row_number, row_result};

endmodule

@@ sim/block_scaled_int8_matvec_core_tb.sv @@
// Self-checking testbench for block_scaled_int8_matvec_core.
// Needs bmv_pkg and the core RTL; a local row predictor checks every row item,
// with random idling on s_axis and random stalls on m_axis.
`timescale 1ns / 100ps

module block_scaled_int8_matvec_core_tb;

  localparam int WeightW   = bmv_pkg::WeightW;
  localparam int ActW      = bmv_pkg::ActW;
  localparam int ScaleW    = bmv_pkg::ScaleW;
  localparam int RowW      = bmv_pkg::RowW;
  localparam int RowNumW   = bmv_pkg::RowNumW;
  localparam int InDataW   = bmv_pkg::InDataW;
  localparam int OutDataW  = bmv_pkg::OutDataW;
  localparam int BlockLen  = bmv_pkg::BlockLen;
  localparam int ScaleFrac = bmv_pkg::ScaleFrac;

  localparam int ClkPeriod  = 20;
  localparam int DrainPause = 20;      // lets the queue and the fold drain, with margin
  localparam int CycleLimit = 400000;  // several times the slowest legal run
  localparam int MaxReports = 10;

  localparam longint BlkMax = 64'sh0000_0000_7FFF_FFFF;
  localparam longint BlkMin = -BlkMax - 1;
  localparam longint RowMax = (64'sd1 <<< (RowW - 1)) - 1;
  localparam longint RowMin = -RowMax - 1;

  // One row item as it should leave m_axis.
  typedef struct {
    logic signed [RowW-1:0] row_result;
    logic [RowNumW-1:0]     row_number;
  } row_item_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [InDataW-1:0]    s_axis_tdata  = '0;
  logic                  s_axis_tlast  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OutDataW-1:0]   m_axis_tdata;
  logic                  cfg_we_i      = 1'b0;
  logic [RowNumW-1:0]    cfg_wdata_i   = '0;

  // Predictor state: mirrors the core's sums, element count and row index.
  longint             dot_block_sum = 0;
  longint             dot_row_sum   = 0;
  int                 dot_elem_cnt  = 0;
  logic [RowNumW-1:0] dot_row_idx   = '0;

  row_item_t pending_rows[$];   // rows predicted but not yet seen on m_axis
  row_item_t got_row;
  int        fail_count   = 0;
  int        sent_items   = 0;
  int        cycle_cnt    = 0;
  int        rx_stall_left = 0;
  bit        idle_en      = 1'b1;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  block_scaled_int8_matvec_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // weight[7:0], activation[23:8], block_scale[39:24]
    .s_axis_tlast  (s_axis_tlast),   // end_of_row
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // row_result[47:0], row_number[63:48]
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Run guard: a hung handshake or a missing row ends here.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: random stall bursts on m_axis_tready while idling is on.
  always @(posedge clk_i) begin
    if (rx_stall_left > 0) begin
      rx_stall_left <= rx_stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_en && ($urandom_range(0, 4) == 0)) begin
      rx_stall_left <= $urandom_range(0, 5);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic note_mismatch(input string what);
    if (fail_count < MaxReports) $display("MISMATCH: %s", what);
    fail_count++;
  endtask

  // Row checker: each accepted row item against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_rows.size() == 0) begin
        note_mismatch($sformatf("unexpected row item tdata=%h", m_axis_tdata));
      end else begin
        got_row = pending_rows.pop_front();
        if (m_axis_tdata[RowW-1:0] !== got_row.row_result ||
            m_axis_tdata[OutDataW-1:RowW] !== got_row.row_number) begin
          note_mismatch($sformatf("row exp result=%0d num=%0d, got result=%0d num=%0d",
                                  got_row.row_result, got_row.row_number,
                                  $signed(m_axis_tdata[RowW-1:0]),
                                  m_axis_tdata[OutDataW-1:RowW]));
        end
      end
    end
  end

  // Predictor step for one accepted element.
  task automatic fold_element(input logic signed [WeightW-1:0] w,
                              input logic signed [ActW-1:0] act,
                              input logic signed [ScaleW-1:0] scl,
                              input logic eor);
    longint acc;
    longint term;
    acc = dot_block_sum + longint'(w) * longint'(act);
    if (acc > BlkMax) acc = BlkMax;
    else if (acc < BlkMin) acc = BlkMin;
    dot_block_sum = acc;
    dot_elem_cnt++;
    // block closes on a full count, or early at row end (partial block)
    if (dot_elem_cnt >= BlockLen || eor) begin
      term = (dot_block_sum * longint'(scl)) >>> ScaleFrac;  // floor
      acc  = dot_row_sum + term;
      if (acc > RowMax) acc = RowMax;
      else if (acc < RowMin) acc = RowMin;
      dot_row_sum   = acc;
      dot_block_sum = 0;
      dot_elem_cnt  = 0;
    end
    if (eor) begin
      pending_rows.push_back('{row_result: dot_row_sum[RowW-1:0], row_number: dot_row_idx});
      dot_row_idx++;   // wraps mod 2^16
      dot_row_sum = 0;
    end
  endtask

  // Sends one element item; tvalid stays high into the next call unless a gap is taken.
  task automatic send_element(input logic signed [WeightW-1:0] w,
                              input logic signed [ActW-1:0] act,
                              input logic signed [ScaleW-1:0] scl,
                              input logic eor);
    if (idle_en && ($urandom_range(0, 7) == 0)) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {scl, act, w};
    s_axis_tlast  <= eor;
    do @(posedge clk_i); while (!s_axis_tready);
    fold_element(w, act, scl, eor);
    sent_items++;
  endtask

  // Holds off s_axis until every predicted row is out, then lets the core settle.
  task automatic wait_rows_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_rows.size() != 0) @(posedge clk_i);
    repeat (DrainPause) @(posedge clk_i);
  endtask

  // first_row write; also reloads the row index at once.
  task automatic write_first_row(input logic [RowNumW-1:0] value);
    wait_rows_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    dot_row_idx = value;
    cfg_we_i    <= 1'b0;
  endtask

  // One row of len elements; hot rows use only extreme weights and activations.
  task automatic send_row(input int len, input bit hot);
    logic signed [WeightW-1:0] w;
    logic signed [ActW-1:0]    act;
    for (int k = 0; k < len; k++) begin
      if (hot) begin
        w   = $urandom_range(0, 1) ? 8'sh80 : 8'sh7F;
        act = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7FFF;
      end else begin
        w   = WeightW'($urandom);
        act = ActW'($urandom);
      end
      send_element(w, act, ScaleW'($urandom), k == len - 1);
    end
  endtask

  // Field extremes, zero, floor of small negatives, and a short partial block.
  task automatic test_extremes();
    send_element(8'sh7F, 16'sh7FFF, 16'sh7FFF, 1'b1);
    send_element(8'sh80, 16'sh8000, 16'sh7FFF, 1'b1);
    send_element(8'sh80, 16'sh7FFF, 16'sh8000, 1'b1);
    send_element(8'sh7F, 16'sh8000, 16'sh8000, 1'b1);
    send_element(8'sh80, 16'sh8000, 16'sh8000, 1'b1);
    send_element(8'sh00, 16'sh0000, 16'sh0000, 1'b1);
    send_element(8'sh01, 16'sh0001, 16'shFFFF, 1'b1);  // -1 >> 12 floors to -1
    send_element(8'sh01, 16'sh0001, 16'sh0001, 1'b1);  // rounds down to 0
    send_element(8'shFF, 16'sh00FF, 16'sh1000, 1'b0);
    send_element(8'sh03, 16'shFF00, 16'sh0000, 1'b0);
    send_element(8'sh05, 16'sh0064, 16'sh1000, 1'b1);  // partial block, scale 1.0
  endtask

  // Row index wraps from 65535 to 0.
  task automatic test_row_wrap();
    write_first_row(16'hFFFF);
    send_element(8'sh01, 16'sh0100, 16'sh1000, 1'b1);
    send_element(8'shFE, 16'sh0100, 16'sh1000, 1'b1);
  endtask

  // Register write in the middle of a row: index reloads, sums carry on.
  task automatic test_cfg_mid_row();
    write_first_row(RowNumW'($urandom));
    send_element(WeightW'($urandom), ActW'($urandom), ScaleW'($urandom), 1'b0);
    send_element(WeightW'($urandom), ActW'($urandom), ScaleW'($urandom), 1'b0);
    write_first_row(RowNumW'($urandom));
    send_element(WeightW'($urandom), ActW'($urandom), ScaleW'($urandom), 1'b0);
    send_element(WeightW'($urandom), ActW'($urandom), ScaleW'($urandom), 1'b1);
  endtask

  // Random rows, mostly short, some around one and two blocks.
  task automatic test_random_rows(input int target, input logic [RowNumW-1:0] row_base);
    int stop_at;
    int pick;
    int len;
    write_first_row(row_base);
    stop_at = sent_items + target;
    while (sent_items < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 92) len = $urandom_range(1, 32);
      else if (pick < 98) len = $urandom_range(BlockLen - 1, BlockLen + 1);
      else len = 2 * BlockLen + $urandom_range(0, 3);
      send_row(len, $urandom_range(0, 7) == 0);
      if ($urandom_range(0, 39) == 0) wait_rows_drained();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extremes();
    test_row_wrap();
    test_cfg_mid_row();
    test_random_rows(650, RowNumW'($urandom));
    test_random_rows(650, 16'hFFF0);
    idle_en = 1'b0;   // closing stretch runs at full rate on both sides
    test_random_rows(600, 16'h0000);

    wait_rows_drained();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
